@@ rtl/core/bcsa_pkg.sv @@
// Shared constants, types and address helpers for the binarized 3x3 scatter-accumulate unit.
package bcsa_pkg;

  // Sizes of the frame and the filter bank.
  localparam int MAX_HEIGHT  = 64;
  localparam int MAX_WIDTH   = 64;
  localparam int MAX_FILTERS = 8;

  // Kernel geometry and vector width.
  localparam int KSIZE    = 3;
  localparam int PAD      = 2;
  localparam int TAPS     = KSIZE * KSIZE;
  localparam int VEC_BITS = 256;
  localparam int WORD_W   = 64;
  localparam int WORDS    = VEC_BITS / WORD_W;

  // Output plane produced by padding on both sides.
  localparam int OUT_H = MAX_HEIGHT + 2 * PAD - KSIZE + 1;
  localparam int OUT_W = MAX_WIDTH + 2 * PAD - KSIZE + 1;

  // Accumulator memory: one entry per output position and filter.
  localparam int ACC_DEPTH = OUT_H * OUT_W * MAX_FILTERS;
  localparam int ACC_AW    = $clog2(ACC_DEPTH);
  localparam int ACC_W     = 13;

  // Filter memory: one full-width tap per entry.
  localparam int FILT_DEPTH = MAX_FILTERS * TAPS;
  localparam int FADDR_W    = $clog2(FILT_DEPTH);

  // Field widths fixed by the interface.
  localparam int DIM_W  = 7;
  localparam int FSEL_W = 3;
  localparam int TAP_W  = 4;
  localparam int NF_W   = 4;
  localparam int KIDX_W = 2;
  localparam int CFG_W  = 7;
  localparam int CIDX_W = 2;

  // Popcount widths.
  localparam int CNT_W = $clog2(WORD_W + 1);
  localparam int PC_W  = $clog2(VEC_BITS + 1);

  // Register reset values.
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT   = 7'd64;
  localparam logic [DIM_W-1:0] RST_FRAME_WIDTH    = 7'd64;
  localparam logic [NF_W-1:0]  RST_FILTERS_IN_USE = 4'd8;

  // Request type codes.
  typedef logic [1:0] req_t;
  localparam req_t REQ_LOAD  = 2'd0;
  localparam req_t REQ_PIXEL = 2'd1;
  localparam req_t REQ_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_FRAME_HEIGHT   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_FRAME_WIDTH    = 2'd1;
  localparam logic [CIDX_W-1:0] REG_FILTERS_IN_USE = 2'd2;

  typedef logic [VEC_BITS-1:0] vec_t;
  typedef logic [CNT_W-1:0]    word_cnt_t;
  typedef word_cnt_t [WORDS-1:0] cnt_vec_t;

  // Linear accumulator address of (output row, output column, filter).
  function automatic logic [ACC_AW-1:0] acc_addr(input logic [DIM_W-1:0]  orow,
                                                 input logic [DIM_W-1:0]  ocol,
                                                 input logic [FSEL_W-1:0] fsel);
    logic [ACC_AW-1:0] pos;
    pos = ACC_AW'(orow) * ACC_AW'(OUT_W) + ACC_AW'(ocol);
    return ACC_AW'(pos * ACC_AW'(MAX_FILTERS) + ACC_AW'(fsel));
  endfunction

  // Filter memory address of (filter, tap).
  function automatic logic [FADDR_W-1:0] filt_addr(input logic [FSEL_W-1:0] fsel,
                                                   input logic [TAP_W-1:0]  tap);
    return FADDR_W'(FADDR_W'(fsel) * FADDR_W'(TAPS) + FADDR_W'(tap));
  endfunction

endpackage

@@ rtl/core/bcsa_xnor_pop.sv @@
// Registered per-word popcount of the XOR between a pixel vector and a filter tap.
module bcsa_xnor_pop
  import bcsa_pkg::*;
(
  input  logic     clk,
  input  vec_t     pix,
  input  vec_t     tap,
  output cnt_vec_t cnt
);

  // Adder tree over one word; each level adds independent pairs.
  function automatic word_cnt_t pop_word(input logic [WORD_W-1:0] v);
    logic [1:0] l1 [WORD_W/2];
    logic [2:0] l2 [WORD_W/4];
    logic [3:0] l3 [WORD_W/8];
    logic [4:0] l4 [WORD_W/16];
    logic [5:0] l5 [WORD_W/32];
    for (int k = 0; k < WORD_W/2; k++) begin
      l1[k] = 2'(v[2*k]) + 2'(v[2*k+1]);
    end
    for (int k = 0; k < WORD_W/4; k++) begin
      l2[k] = 3'(l1[2*k]) + 3'(l1[2*k+1]);
    end
    for (int k = 0; k < WORD_W/8; k++) begin
      l3[k] = 4'(l2[2*k]) + 4'(l2[2*k+1]);
    end
    for (int k = 0; k < WORD_W/16; k++) begin
      l4[k] = 5'(l3[2*k]) + 5'(l3[2*k+1]);
    end
    for (int k = 0; k < WORD_W/32; k++) begin
      l5[k] = 6'(l4[2*k]) + 6'(l4[2*k+1]);
    end
    return CNT_W'(l5[0]) + CNT_W'(l5[1]);
  endfunction

  vec_t diff;

  assign diff = pix ^ tap;

  always_ff @(posedge clk) begin
    for (int w = 0; w < WORDS; w++) begin
      cnt[w] <= pop_word(diff[w*WORD_W +: WORD_W]);
    end
  end

endmodule

@@ rtl/core/binarized_conv3x3_scatter_accumulate_unit.sv @@
// Top level of the binarized 3x3 convolution unit with scatter accumulation into memory.
//
// Usage: items arrive on the in_ valid/ready channel. A load transaction writes one
// 256-bit filter tap and leaves the input ready. A pixel transaction inside the frame
// scatters its XNOR-popcount against all nine taps of every filter in use into the
// accumulator memory via the single read-modify-write pipeline on that memory, which
// retires one tap per cycle; in_ready stays low until the last write retires. A read
// transaction returns one accumulator on the out_ valid/ready channel, clears that
// entry and keeps in_ready low until its result enters the output register. Pixels
// outside the frame and unused request codes leave the input ready. After reset the
// accumulator memory is swept to zero, one entry per cycle; in_ready stays low during
// that sweep while configuration writes on the cfg_ port are still taken. The result
// sits in an output register: if the receiver stalls, loads and pixels are still
// accepted, and a further read waits in its final step until the register is free.
module binarized_conv3x3_scatter_accumulate_unit
  import bcsa_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  // Configuration write port.
  input  logic                    cfg_we,
  input  logic [CIDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata,
  // Input channel.
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_req_type,
  input  logic [DIM_W-1:0]        in_row,
  input  logic [DIM_W-1:0]        in_col,
  input  logic [FSEL_W-1:0]       in_filter_index,
  input  logic [TAP_W-1:0]        in_tap,
  input  logic [WORD_W-1:0]       in_word0,
  input  logic [WORD_W-1:0]       in_word1,
  input  logic [WORD_W-1:0]       in_word2,
  input  logic [WORD_W-1:0]       in_word3,
  // Result channel.
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [ACC_W-1:0] out_accumulated_sum
);

  // Sequencer states.
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_PIX   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [ACC_AW-1:0] clr_cnt_r;

  // Configuration registers and their saturated views.
  logic [DIM_W-1:0] frame_height_r, frame_width_r;
  logic [NF_W-1:0]  filters_in_use_r;
  logic [DIM_W-1:0] h_eff, w_eff;
  logic [NF_W-1:0]  nf_eff;

  // Memories.
  logic [VEC_BITS-1:0] filt_mem [FILT_DEPTH];
  logic [ACC_W-1:0]    acc_mem  [ACC_DEPTH];
  vec_t                filt_q_r;
  logic [ACC_W-1:0]    acc_q_r;

  // Pixel being scattered and its tap counters.
  vec_t               pix_r;
  logic [DIM_W-1:0]   pix_row_r, pix_col_r;
  logic [FSEL_W-1:0]  f_cnt_r;
  logic [KIDX_W-1:0]  i_cnt_r, j_cnt_r;
  logic               last_tap;

  // Read-modify-write pipeline.
  logic               s1_vld_r, s2_vld_r;
  logic [ACC_AW-1:0]  s1_addr_r, s2_addr_r;
  cnt_vec_t           cnt;
  logic [PC_W-1:0]    pc_sum;
  logic [ACC_W-1:0]   contrib, acc_sum;

  // Pending read.
  logic               rd_ok_r;
  logic [ACC_AW-1:0]  rd_addr_r;

  // Output register.
  logic               out_valid_r;
  logic [ACC_W-1:0]   out_sum_r;
  logic               out_free;

  // Decoded input.
  logic               accept;
  logic               in_frame, rd_in_range, load_ok;
  logic [ACC_AW-1:0]  rd_in_addr;
  logic [DIM_W-1:0]   orow, ocol;

  // Accumulator memory ports.
  logic               acc_we, acc_re;
  logic [ACC_AW-1:0]  acc_waddr, acc_raddr;
  logic [ACC_W-1:0]   acc_wdata;

  // Register values above the maxima act as the maxima.
  assign h_eff  = (frame_height_r > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : frame_height_r;
  assign w_eff  = (frame_width_r > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : frame_width_r;
  assign nf_eff = (filters_in_use_r > NF_W'(MAX_FILTERS)) ? NF_W'(MAX_FILTERS)
                                                           : filters_in_use_r;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign in_frame    = (in_row < h_eff) && (in_col < w_eff);
  assign rd_in_range = (32'(in_row) < OUT_H) && (32'(in_col) < OUT_W) &&
                       (32'(in_filter_index) < MAX_FILTERS);
  assign load_ok     = (32'(in_tap) < TAPS) && (32'(in_filter_index) < MAX_FILTERS);
  assign rd_in_addr  = acc_addr(in_row, in_col, in_filter_index);

  // Output position reached by the current tap.
  assign orow = DIM_W'(pix_row_r + DIM_W'(PAD) - DIM_W'(i_cnt_r));
  assign ocol = DIM_W'(pix_col_r + DIM_W'(PAD) - DIM_W'(j_cnt_r));

  assign last_tap = (32'(i_cnt_r) == KSIZE - 1) && (32'(j_cnt_r) == KSIZE - 1) &&
                    (NF_W'(f_cnt_r) == NF_W'(nf_eff - NF_W'(1)));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_height_r   <= RST_FRAME_HEIGHT;
      frame_width_r    <= RST_FRAME_WIDTH;
      filters_in_use_r <= RST_FILTERS_IN_USE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_HEIGHT:   frame_height_r   <= cfg_wdata;
        REG_FRAME_WIDTH:    frame_width_r    <= cfg_wdata;
        REG_FILTERS_IN_USE: filters_in_use_r <= NF_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == ACC_AW'(ACC_DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_req_type)
            REQ_PIXEL: begin
              if (in_frame && (nf_eff != '0)) state_nxt = ST_PIX;
            end
            REQ_READ: state_nxt = ST_READ;
            default: ;
          endcase
        end
      end
      ST_PIX: begin
        if (last_tap) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        // The final write retires at the end of the cycle in which stage one is empty.
        if (!s1_vld_r) state_nxt = ST_IDLE;
      end
      ST_READ: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + ACC_AW'(1);
    end
  end

  // Tap counters walk j fastest, then i, then the filter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_cnt_r <= '0;
      i_cnt_r <= '0;
      j_cnt_r <= '0;
    end else if (accept) begin
      f_cnt_r <= '0;
      i_cnt_r <= '0;
      j_cnt_r <= '0;
    end else if (state_r == ST_PIX) begin
      if (32'(j_cnt_r) == KSIZE - 1) begin
        j_cnt_r <= '0;
        if (32'(i_cnt_r) == KSIZE - 1) begin
          i_cnt_r <= '0;
          f_cnt_r <= f_cnt_r + FSEL_W'(1);
        end else begin
          i_cnt_r <= i_cnt_r + KIDX_W'(1);
        end
      end else begin
        j_cnt_r <= j_cnt_r + KIDX_W'(1);
      end
    end
  end

  // Pixel payload and pending read, captured at acceptance.
  always_ff @(posedge clk) begin
    if (accept && (in_req_type == REQ_PIXEL)) begin
      pix_r     <= {in_word3, in_word2, in_word1, in_word0};
      pix_row_r <= in_row;
      pix_col_r <= in_col;
    end
    if (accept && (in_req_type == REQ_READ)) begin
      rd_addr_r <= rd_in_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ok_r <= 1'b0;
    end else if (accept && (in_req_type == REQ_READ)) begin
      rd_ok_r <= rd_in_range;
    end
  end

  // Filter memory: loads write, the tap issue stage reads.
  always_ff @(posedge clk) begin
    if (accept && (in_req_type == REQ_LOAD) && load_ok) begin
      filt_mem[filt_addr(in_filter_index, in_tap)] <= {in_word3, in_word2, in_word1, in_word0};
    end
    if (state_r == ST_PIX) begin
      filt_q_r <= filt_mem[filt_addr(f_cnt_r,
                                     TAP_W'(TAP_W'(i_cnt_r) * TAP_W'(KSIZE) + TAP_W'(j_cnt_r)))];
    end
  end

  // Pipeline control: stage one holds filter data, stage two holds counts and old sum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= (state_r == ST_PIX);
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r <= acc_addr(orow, ocol, f_cnt_r);
    s2_addr_r <= s1_addr_r;
  end

  bcsa_xnor_pop u_pop (
    .clk (clk),
    .pix (pix_r),
    .tap (filt_q_r),
    .cnt (cnt)
  );

  // Contribution is 256 minus twice the mismatch count, wrapped to the accumulator width.
  always_comb begin
    pc_sum = '0;
    for (int w = 0; w < WORDS; w++) begin
      pc_sum = pc_sum + PC_W'(cnt[w]);
    end
  end

  assign contrib = ACC_W'(VEC_BITS) - ACC_W'({pc_sum, 1'b0});
  assign acc_sum = acc_q_r + contrib;

  // Accumulator memory ports. Within one pixel every tap hits a distinct entry, and
  // pixels do not overlap, so no forwarding path is needed.
  always_comb begin
    acc_we    = 1'b0;
    acc_waddr = s2_addr_r;
    acc_wdata = acc_sum;
    if (state_r == ST_CLEAR) begin
      acc_we    = 1'b1;
      acc_waddr = clr_cnt_r;
      acc_wdata = '0;
    end else if (s2_vld_r) begin
      acc_we = 1'b1;
    end else if ((state_r == ST_READ) && out_free && rd_ok_r) begin
      acc_we    = 1'b1;
      acc_waddr = rd_addr_r;
      acc_wdata = '0;
    end
  end

  assign acc_re    = s1_vld_r || (accept && (in_req_type == REQ_READ) && rd_in_range);
  assign acc_raddr = s1_vld_r ? s1_addr_r : rd_in_addr;

  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
    if (acc_re) acc_q_r <= acc_mem[acc_raddr];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_READ) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_READ) && out_free) begin
      out_sum_r <= rd_ok_r ? acc_q_r : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_accumulated_sum = $signed(out_sum_r);

`ifndef SYNTHESIS
  // Accumulator writes from the pipeline only happen while a pixel is being scattered.
  a_rmw_in_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |-> ((state_r == ST_PIX) || (state_r == ST_DRAIN) || (state_r == ST_IDLE)))
    else $error("accumulator write outside a pixel scatter");

  // An accepted read always moves to the read completion step.
  a_read_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req_type == REQ_READ)) |=> (state_r == ST_READ))
    else $error("read transaction did not enter the read step");

  // A new result only appears after the read step.
  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_READ))
    else $error("result raised without a read");

  // No item is taken while the pipeline still holds work.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r |-> !in_ready)
    else $error("input accepted while the pipeline is busy");
`endif

endmodule
